/* sv/lgf_pkg.sv */
// ----------------------------------------------------------------------------
// lgf_pkg: shared types, constants, the free-beam test and run-tracking functions
// Widths of the beam stream, configuration codes, the word that goes from
// the classifying front end through the queue to the gap tracker, and the
// run-length update step used by the tracker.
// ----------------------------------------------------------------------------
package lgf_pkg;

  // Field widths
  localparam int unsigned RangeW   = 16;
  localparam int unsigned IdxW     = 12;
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned AngMinW  = 23;
  localparam int unsigned StepW    = 17;
  localparam int unsigned AngW     = 30;
  localparam int unsigned ProdW    = IdxW + StepW;
  localparam int unsigned SumW     = RangeW + 3;
  localparam int unsigned TapCntW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 23;

  // Scan limit and smoothing window
  localparam int unsigned MaxBeams = 2 ** IdxW;
  localparam int unsigned Taps     = 5;
  localparam int unsigned HistLen  = Taps - 1;

  // Queue between classifier and tracker
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;

  // Register reset values
  localparam logic [ThrW-1:0]           ThrRst     = ThrW'(500);
  localparam logic signed [AngMinW-1:0] AngMinRst  = -AngMinW'(2356194);
  localparam logic [StepW-1:0]          StepRst    = StepW'(4363);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAP_THRESHOLD = 2'd0,
    CFG_ANGLE_MIN     = 2'd1,
    CFG_ANGLE_STEP    = 2'd2
  } cfg_reg_e;

  // Classified beam word
  typedef struct packed {
    logic            trk_v;       // a beam left the window centre
    logic            trk_free;    // that beam is above threshold
    logic [IdxW-1:0] trk_idx;     // its index
    logic            last;        // scan closes with this word
    logic            fl_lo_v;     // second to last beam is flushed
    logic            fl_lo_free;
    logic            fl_hi_free;  // last beam, always flushed on close
    logic [CntW-1:0] len;         // scan length on close
  } beam_word_t;

  // Run tracker state
  typedef struct packed {
    logic [IdxW-1:0] run_start;
    logic [CntW-1:0] run_len;
    logic [IdxW-1:0] best_start;
    logic [CntW-1:0] best_len;
  } run_t;

  // Smoothed range above threshold, tested as sum > thr * taps
  function automatic logic beam_free(logic [SumW-1:0] sum, logic [ThrW-1:0] thr,
                                     logic [TapCntW-1:0] cnt);
    logic [SumW-1:0] lim;
    lim = SumW'(thr) * SumW'(cnt);
    return sum > lim;
  endfunction

  // Keep the longer run; on a tie the earlier one stays
  function automatic run_t run_close(run_t s);
    run_t r;
    r = s;
    if (s.run_len > s.best_len) begin
      r.best_start = s.run_start;
      r.best_len   = s.run_len;
    end
    r.run_len = '0;
    return r;
  endfunction

  // Extend or close the current run with one beam
  function automatic run_t run_step(run_t s, logic free, logic [IdxW-1:0] c);
    run_t r;
    r = s;
    if (free) begin
      if (s.run_len == '0) begin
        r.run_start = c;
      end
      r.run_len = s.run_len + CntW'(1);
    end else begin
      r = run_close(s);
    end
    return r;
  endfunction

endpackage

/* sv/lgf_ifs.sv */
// ----------------------------------------------------------------------------
// lgf_smp_if / lgf_res_if: beam and steering result channels
// Valid/ready channels; a word moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface lgf_smp_if;
  import lgf_pkg::*;

  logic              valid;
  logic              ready;
  logic [RangeW-1:0] range_mm;
  logic              range_invalid;
  logic              last_sample;

  modport source (output valid, range_mm, range_invalid, last_sample, input ready);
  modport sink   (input valid, range_mm, range_invalid, last_sample, output ready);
endinterface

interface lgf_res_if;
  import lgf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [IdxW-1:0]        best_index;
  logic signed [AngW-1:0] steer_angle_urad;
  logic [CntW-1:0]        gap_length;
  logic                   gap_found;

  modport source (output valid, best_index, steer_angle_urad, gap_length, gap_found,
                  input ready);
  modport sink   (input valid, best_index, steer_angle_urad, gap_length, gap_found,
                  output ready);
endinterface

/* sv/lgf_front.sv */
// ----------------------------------------------------------------------------
// lgf_front: beam window and free-beam classifier
// Holds the last four beams and the beam count, smooths the beam two places
// back over five taps and, on the closing beam, the two beams still pending.
// ----------------------------------------------------------------------------
module lgf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lgf_smp_if.sink                       smp_i,
  input  logic [lgf_pkg::ThrW-1:0]      thr_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output lgf_pkg::beam_word_t           word_o
);
  import lgf_pkg::*;

  logic [RangeW-1:0]  hist_q [HistLen];
  logic [RangeW-1:0]  hist_d [HistLen];
  logic [CntW-1:0]    count_q, count_d;

  logic               hs;
  logic               in_scan;
  logic [RangeW-1:0]  beam;
  logic [RangeW-1:0]  win [HistLen];
  logic [CntW-1:0]    len;
  logic [SumW-1:0]    trk_sum, lo_sum, hi_sum;
  logic [TapCntW-1:0] trk_cnt, lo_cnt, hi_cnt;

  // Stall only on a full queue
  assign smp_i.ready = !q_full_i;
  assign hs          = smp_i.valid && smp_i.ready;
  assign in_scan     = count_q < CntW'(MaxBeams);
  assign beam        = smp_i.range_invalid ? '0 : smp_i.range_mm;

  // Window after this beam, newest first
  always_comb begin
    if (in_scan) begin
      win[0] = beam;
      for (int k = 1; k < HistLen; k++) begin
        win[k] = hist_q[k-1];
      end
      len = count_q + CntW'(1);
    end else begin
      win = hist_q;
      len = count_q;
    end
  end

  // Tap sums and in-scan tap counts
  always_comb begin
    trk_sum = SumW'(beam);
    for (int k = 0; k < HistLen; k++) begin
      trk_sum = trk_sum + SumW'(hist_q[k]);
    end
    lo_sum = SumW'(win[0]) + SumW'(win[1]) + SumW'(win[2]) + SumW'(win[3]);
    hi_sum = SumW'(win[0]) + SumW'(win[1]) + SumW'(win[2]);
    trk_cnt = (count_q >= CntW'(4)) ? TapCntW'(5) : TapCntW'(count_q + CntW'(1));
    lo_cnt  = (len >= CntW'(4)) ? TapCntW'(4) : TapCntW'(len);
    hi_cnt  = (len >= CntW'(3)) ? TapCntW'(3) : TapCntW'(len);
  end

  // Build the classified word
  always_comb begin
    word_o.trk_v      = in_scan && (count_q >= CntW'(2));
    word_o.trk_free   = beam_free(trk_sum, thr_i, trk_cnt);
    word_o.trk_idx    = IdxW'(count_q - CntW'(2));
    word_o.last       = smp_i.last_sample;
    word_o.fl_lo_v    = len >= CntW'(2);
    word_o.fl_lo_free = beam_free(lo_sum, thr_i, lo_cnt);
    word_o.fl_hi_free = beam_free(hi_sum, thr_i, hi_cnt);
    word_o.len        = len;
  end

  assign push_o = hs && (word_o.trk_v || smp_i.last_sample);

  // Advance the window; clear it when the scan closes
  always_comb begin
    hist_d  = hist_q;
    count_d = count_q;
    if (hs) begin
      if (smp_i.last_sample) begin
        for (int k = 0; k < HistLen; k++) begin
          hist_d[k] = '0;
        end
        count_d = '0;
      end else if (in_scan) begin
        hist_d  = win;
        count_d = len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HistLen; k++) begin
        hist_q[k] <= '0;
      end
      count_q <= '0;
    end else begin
      hist_q  <= hist_d;
      count_q <= count_d;
    end
  end

endmodule

/* sv/lgf_queue.sv */
// ----------------------------------------------------------------------------
// lgf_queue: short word queue between classifier and gap tracker
// First-in first-out store of classified beam words; head is shown directly.
// ----------------------------------------------------------------------------
module lgf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lgf_pkg::beam_word_t push_word_i,
  output logic                full_o,
  input  logic                pop_i,
  output lgf_pkg::beam_word_t head_o,
  output logic                empty_o
);
  import lgf_pkg::*;

  beam_word_t          mem_q [QueueDepth];
  logic [QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]      fill_q, fill_d;

  assign full_o  = fill_q == (QPtrW+1)'(QueueDepth);
  assign empty_o = fill_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + (QPtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

/* sv/lgf_back.sv */
// ----------------------------------------------------------------------------
// lgf_back: gap tracker and steering angle pipeline
// Applies each classified word to the run tracker; on scan close picks the
// target beam, multiplies by the step, adds the base angle and saturates.
// ----------------------------------------------------------------------------
module lgf_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lgf_pkg::beam_word_t                 head_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  input  logic signed [lgf_pkg::AngMinW-1:0]  ang_min_i,
  input  logic [lgf_pkg::StepW-1:0]           step_i,
  lgf_res_if.source                           res_o
);
  import lgf_pkg::*;

  localparam logic signed [AngW:0] AngHi = (AngW+1)'((2 ** (AngW-1)) - 1);
  localparam logic signed [AngW:0] AngLo = -(AngW+1)'(2 ** (AngW-1));

  run_t                   run_q, run_d;
  run_t                   s_trk, s_lo, s_hi, s_end;
  logic                   found;
  logic [IdxW-1:0]        pick;

  logic                   r1_v_q, r2_v_q, out_v_q;
  logic [IdxW-1:0]        r1_idx_q, r2_idx_q;
  logic [CntW-1:0]        r1_len_q, r2_len_q;
  logic                   r1_found_q, r2_found_q;
  logic [ProdW-1:0]       prod_q;
  logic                   out_free, r2_free, r1_free;
  logic signed [AngW:0]   ang_sum, ang_sat;

  logic [IdxW-1:0]        out_idx_q;
  logic signed [AngW-1:0] out_ang_q;
  logic [CntW-1:0]        out_len_q;
  logic                   out_found_q;

  // Stage readiness, back to front
  assign out_free = !out_v_q || res_o.ready;
  assign r2_free  = !r2_v_q || out_free;
  assign r1_free  = !r1_v_q || r2_free;
  assign pop_o    = !empty_i && (!head_i.last || r1_free);

  // Run tracking: centre beam, then the flushed tail on close
  always_comb begin
    s_trk = head_i.trk_v ? run_step(run_q, head_i.trk_free, head_i.trk_idx) : run_q;
    s_lo  = head_i.fl_lo_v ?
            run_step(s_trk, head_i.fl_lo_free, IdxW'(head_i.len - CntW'(2))) : s_trk;
    s_hi  = run_step(s_lo, head_i.fl_hi_free, IdxW'(head_i.len - CntW'(1)));
    s_end = run_close(s_hi);
    found = s_end.best_len != '0;
    pick  = found ? s_end.best_start + s_end.best_len[IdxW:1] : head_i.len[IdxW:1];
  end

  always_comb begin
    run_d = run_q;
    if (pop_o) begin
      run_d = head_i.last ? '0 : s_trk;
    end
  end

  // Base angle plus offset, clamped to the output range
  always_comb begin
    ang_sum = (AngW+1)'(ang_min_i) + $signed({2'b00, prod_q});
    if (ang_sum > AngHi) begin
      ang_sat = AngHi;
    end else if (ang_sum < AngLo) begin
      ang_sat = AngLo;
    end else begin
      ang_sat = ang_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      r1_v_q  <= 1'b0;
      r2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      run_q <= run_d;
      if (r1_free) begin
        r1_v_q <= pop_o && head_i.last;
      end
      if (r2_free) begin
        r2_v_q <= r1_v_q;
      end
      if (out_free) begin
        out_v_q <= r2_v_q;
      end
    end
  end

  // Result payload: pick, multiply, add
  always_ff @(posedge clk_i) begin
    if (r1_free && pop_o && head_i.last) begin
      r1_idx_q   <= pick;
      r1_len_q   <= s_end.best_len;
      r1_found_q <= found;
    end
    if (r2_free && r1_v_q) begin
      prod_q     <= ProdW'(r1_idx_q) * ProdW'(step_i);
      r2_idx_q   <= r1_idx_q;
      r2_len_q   <= r1_len_q;
      r2_found_q <= r1_found_q;
    end
    if (out_free && r2_v_q) begin
      out_idx_q   <= r2_idx_q;
      out_ang_q   <= AngW'(ang_sat);
      out_len_q   <= r2_len_q;
      out_found_q <= r2_found_q;
    end
  end

  assign res_o.valid            = out_v_q;
  assign res_o.best_index       = out_idx_q;
  assign res_o.steer_angle_urad = out_ang_q;
  assign res_o.gap_length       = out_len_q;
  assign res_o.gap_found        = out_found_q;

endmodule

/* sv/lidar_gap_follow_steering.sv */
// ----------------------------------------------------------------------------
// lidar_gap_follow_steering: follow-the-gap steering target from a lidar scan
// Streams one range beam per word on smp_i, smooths each over five beams,
// tracks the longest free gap and gives one steering word per scan on res_o.
//
// Usage:
//   smp_i carries range_mm, range_invalid (range read as zero) and
//   last_sample, which closes the scan. res_o carries best_index,
//   steer_angle_urad, gap_length and gap_found, one word per scan.
//   The cfg port writes threshold, base angle and angle step by index;
//   write it only while no scan is in flight.
//   Throughput: one beam per cycle while the queue is not full, set by the
//   run tracker that drains the four-word queue behind the classifier.
//   The closing beam's result is registered in turn through the queue, the
//   pick stage, the multiply stage and the add and clamp into the output.
//   Reset clears the beam window, the tracker and the queue and loads
//   the register defaults. A stalled receiver holds the output word; the
//   pipeline and queue fill behind it and then smp_i.ready drops.
// ----------------------------------------------------------------------------
module lidar_gap_follow_steering (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lgf_smp_if.sink                         smp_i,
  lgf_res_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  logic [lgf_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lgf_pkg::CfgDataW-1:0]    cfg_data_i
);
  import lgf_pkg::*;

  logic [ThrW-1:0]           thr_q;
  logic signed [AngMinW-1:0] ang_min_q;
  logic [StepW-1:0]          step_q;

  logic                      push, full, pop, empty;
  beam_word_t                push_word, head;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThrRst;
      ang_min_q <= AngMinRst;
      step_q    <= StepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GAP_THRESHOLD: thr_q     <= ThrW'(cfg_data_i);
        CFG_ANGLE_MIN:     ang_min_q <= $signed(AngMinW'(cfg_data_i));
        CFG_ANGLE_STEP:    step_q    <= StepW'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  lgf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .smp_i    (smp_i),
    .thr_i    (thr_q),
    .q_full_i (full),
    .push_o   (push),
    .word_o   (push_word)
  );

  lgf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  lgf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .ang_min_i (ang_min_q),
    .step_i    (step_q),
    .res_o     (res_o)
  );

endmodule
